// ===== design/sfc_pkg.sv =====
// Package for the serial frame checker: constants, item and result types,
// status codes and the CRC-16/XMODEM byte update. No dependencies.
package sfc_pkg;

    localparam int unsigned FRAME_BUFFER_BYTES_DEF = 64;
    localparam int unsigned FRAME_BUFFER_MIN       = 6;
    localparam int unsigned FRAME_BUFFER_MAX       = 256;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [8:0]  FRAME_OVERHEAD  = 9'd4;
    localparam logic [8:0]  MIN_FRAME_BYTES = 9'd6;

    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] STOP_MARKER_RST  = 8'h03;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_MARKER  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_BAD_DELIM    = 2'd1,
        STAT_CRC_MISMATCH = 2'd2,
        STAT_BAD_LENGTH   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } item_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  command_code;
        logic [5:0]  last_position;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // Handshake between the input register and the frame checker
    typedef struct packed {
        logic take;     // checker consumes the held item this cycle
        logic free;     // result register can accept a new result
    } stage_ctrl_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// ===== design/sfc_if.sv =====
// Channel interfaces of the serial frame checker: received bytes in,
// frame results out. Depends on nothing but plain logic types.
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  command_code;
    logic [5:0]  last_position;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    modport source (output valid, output frame_status, output command_code,
                    output last_position, output computed_crc,
                    output received_crc, input ready);
    modport sink   (input valid, input frame_status, input command_code,
                    input last_position, input computed_crc,
                    input received_crc, output ready);
endinterface

// ===== design/sfc_in_reg.sv =====
// Input register of the serial frame checker: holds one received item.
// Depends on sfc_pkg.
module sfc_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sfc_pkg::item_t       in_item,
    input  sfc_pkg::stage_ctrl_t ctrl,
    output logic                 held_valid,
    output sfc_pkg::item_t       held_item
);

    logic           valid_reg;
    logic           valid_next;
    sfc_pkg::item_t item_reg;
    logic           load;

    assign in_ready = !valid_reg || ctrl.free;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (ctrl.take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== design/sfc_frame_check.sv =====
// Frame tracker and checker: keeps per-frame state, the running CRC and the
// marker registers, and forms the result when a frame closes. Uses sfc_pkg.
module sfc_frame_check
#(
    parameter int unsigned FRAME_BUFFER_BYTES = sfc_pkg::FRAME_BUFFER_BYTES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    input  logic                               held_valid,
    input  sfc_pkg::item_t                     held_item,
    input  logic                               out_free,
    output sfc_pkg::stage_ctrl_t               ctrl,
    output logic                               res_valid,
    output sfc_pkg::result_t                   res_data
);

    localparam int unsigned POS_W = $clog2(FRAME_BUFFER_BYTES);
    localparam logic [8:0]  LAST_POS = 9'(FRAME_BUFFER_BYTES - 1);

    logic [7:0]       start_marker_reg;
    logic [7:0]       stop_marker_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       first_reg;
    logic [7:0]       first_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;
    logic [7:0]       cmd_reg;
    logic [7:0]       cmd_next;
    logic [15:0]      recent_reg;
    logic [15:0]      recent_next;

    logic             fire;
    logic             close;
    logic [8:0]       pos_ext;
    logic [8:0]       count;
    logic [7:0]       b;
    logic [7:0]       first_cur;
    logic [7:0]       len_cur;
    logic [7:0]       cmd_cur;
    logic [15:0]      crc_cur;
    logic             crc_en;
    sfc_pkg::status_t status;

    assign fire      = held_valid && out_free;
    assign ctrl.take = fire;
    assign ctrl.free = out_free;

    assign b       = held_item.rx_byte;
    assign pos_ext = 9'(pos_reg);
    assign count   = pos_ext + 9'd1;
    assign close   = held_item.burst_end || (pos_ext == LAST_POS);

    // Capture the header bytes as they pass
    assign first_cur = (pos_ext == 9'd0) ? b : first_reg;
    assign len_cur   = (pos_ext == 9'd1) ? b : len_reg;
    assign cmd_cur   = (pos_ext == 9'd2) ? b : cmd_reg;

    // Covered bytes: positions 1 .. length-4
    assign crc_en  = (pos_ext != 9'd0) &&
                     ((pos_ext + sfc_pkg::FRAME_OVERHEAD) <= {1'b0, len_cur});
    assign crc_cur = crc_en ? sfc_pkg::crc_update(crc_reg, b) : crc_reg;

    always_comb
    begin
        if (first_cur != start_marker_reg || b != stop_marker_reg)
            status = sfc_pkg::STAT_BAD_DELIM;
        else if (count < sfc_pkg::MIN_FRAME_BYTES || {1'b0, len_cur} != count)
            status = sfc_pkg::STAT_BAD_LENGTH;
        else if (crc_cur != recent_reg)
            status = sfc_pkg::STAT_CRC_MISMATCH;
        else
            status = sfc_pkg::STAT_OK;
    end

    assign res_valid              = fire && close;
    assign res_data.frame_status  = status;
    assign res_data.command_code  = cmd_cur;
    assign res_data.last_position = pos_ext[5:0];
    assign res_data.computed_crc  = crc_cur;
    assign res_data.received_crc  = recent_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        cmd_next    = cmd_reg;
        recent_next = recent_reg;
        if (fire)
        begin
            if (close)
            begin
                pos_next    = '0;
                crc_next    = sfc_pkg::CRC_INIT;
                first_next  = '0;
                len_next    = '0;
                cmd_next    = '0;
                recent_next = '0;
            end
            else
            begin
                pos_next    = count[POS_W-1:0];
                crc_next    = crc_cur;
                first_next  = first_cur;
                len_next    = len_cur;
                cmd_next    = cmd_cur;
                recent_next = {recent_reg[7:0], b};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= sfc_pkg::CRC_INIT;
            first_reg  <= '0;
            len_reg    <= '0;
            cmd_reg    <= '0;
            recent_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
            cmd_reg    <= cmd_next;
            recent_reg <= recent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= sfc_pkg::START_MARKER_RST;
            stop_marker_reg  <= sfc_pkg::STOP_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfc_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                sfc_pkg::CFG_STOP_MARKER:  stop_marker_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/sfc_out_reg.sv =====
// Result register of the serial frame checker: holds one result until the
// receiver takes it. Depends on sfc_pkg.
module sfc_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  sfc_pkg::result_t load_data,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output sfc_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    sfc_pkg::result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_valid)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/serial_frame_checker_crc16_unit.sv =====
// Top level of the serial frame checker with CRC-16/XMODEM.
// Depends on sfc_pkg, sfc_if, sfc_in_reg, sfc_frame_check, sfc_out_reg.
//
// Usage:
//   rx  : one received byte per item, with burst_end set on the last byte of
//         a burst. A frame closes on that byte or when the frame buffer
//         (FRAME_BUFFER_BYTES bytes) fills.
//   res : one item per closed frame: status, command byte, byte count minus
//         one, computed CRC and the CRC carried in the frame.
//   cfg : write port for the start and stop markers (index 0 and 1); write
//         only while no frame is in flight.
// Path: an accepted byte is registered in the input register and checked
//   there; a result it closes is registered in the result register for res.
// Throughput: one byte per cycle unless a result waits; the per-byte CRC
//   update is an 8-step shift/xor network between input and result registers.
// Reset: all frame state clears, markers return to 0x02 / 0x03, both
//   registers empty. No clearing pass is needed.
// Stall: while a result waits, one more byte can still be taken into the
//   input register; the frame state then holds until res is taken.
module serial_frame_checker_crc16_unit
#(
    parameter int unsigned FRAME_BUFFER_BYTES = sfc_pkg::FRAME_BUFFER_BYTES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    sfc_in_if.sink                          rx,
    sfc_out_if.source                       res,
    input  logic                            cfg_we,
    input  logic [sfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    sfc_pkg::item_t       rx_item;
    sfc_pkg::item_t       held_item;
    logic                 held_valid;
    sfc_pkg::stage_ctrl_t ctrl;
    logic                 out_free;
    logic                 chk_valid;
    sfc_pkg::result_t     chk_data;
    sfc_pkg::result_t     res_data;

    // Pack the incoming channel into an item
    assign rx_item.rx_byte   = rx.rx_byte;
    assign rx_item.burst_end = rx.burst_end;

    sfc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_item    (rx_item),
        .ctrl       (ctrl),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Frame state, running CRC and checks
    sfc_frame_check #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_frame_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .held_valid (held_valid),
        .held_item  (held_item),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .res_valid  (chk_valid),
        .res_data   (chk_data)
    );

    // Hold the result until the receiver takes it
    sfc_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (chk_valid),
        .load_data  (chk_data),
        .free       (out_free),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_data   (res_data)
    );

    assign res.frame_status  = res_data.frame_status;
    assign res.command_code  = res_data.command_code;
    assign res.last_position = res_data.last_position;
    assign res.computed_crc  = res_data.computed_crc;
    assign res.received_crc  = res_data.received_crc;

endmodule
